// ===== hdl/ssq_pkg.sv =====
package ssq_pkg;

  localparam int unsigned QUEUE_DEPTH = 16;
  localparam int unsigned QIDX_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CNT_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned QCNT_W      = 5;

  typedef enum logic [1:0] {
    REQ_ENQUEUE  = 2'd0,
    REQ_START    = 2'd1,
    REQ_DEADLINE = 2'd2
  } req_e;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_RISE = 2'd1,
    PH_FALL = 2'd2
  } phase_e;

  typedef enum logic {
    CTL_IDLE,
    CTL_EXEC
  } ctl_e;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [31:0] now;
    logic [31:0] seg_step_count;
    logic [31:0] seg_start_time;
    logic [31:0] seg_period;
    logic [31:0] seg_pulse_width;
    logic        seg_direction;
  } in_req_t;

  typedef struct packed {
    logic              accepted;
    logic              set_direction;
    logic              direction_out;
    logic              raise_step;
    logic              lower_step;
    logic              segment_done;
    logic              queue_empty;
    logic              due_valid;
    logic [31:0]       due_at;
    logic [31:0]       late_ticks;
    logic [QCNT_W-1:0] queued_count;
  } out_res_t;

  typedef struct packed {
    logic [31:0] count;
    logic [31:0] start;
    logic [31:0] period;
    logic [31:0] width;
    logic        dir;
  } seg_t;

  localparam int unsigned SEG_W = $bits(seg_t);

endpackage

// ===== hdl/ssq_seg_ram.sv =====
module ssq_seg_ram #(
  parameter int unsigned DataWidth = 8,
  parameter int unsigned Depth     = 16,
  parameter int unsigned AddrWidth = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic                 clk_i,
  input  logic                 we_i,
  input  logic [AddrWidth-1:0] waddr_i,
  input  logic [DataWidth-1:0] wdata_i,
  input  logic                 re_i,
  input  logic [AddrWidth-1:0] raddr_i,
  output logic [DataWidth-1:0] rdata_o
);

  logic [DataWidth-1:0] mem_q [Depth];
  logic [DataWidth-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/ssq_engine.sv =====
module ssq_engine (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  ssq_pkg::in_req_t in_req_i,
  output logic             res_valid_o,
  input  logic             res_ready_i,
  output ssq_pkg::out_res_t res_o
);
  import ssq_pkg::*;

  ctl_e ctl_q, ctl_d;
  in_req_t req_q;

  logic [QIDX_W-1:0] head_q, head_d;
  logic [CNT_W-1:0]  fill_q, fill_d;
  phase_e            phase_q, phase_d;
  logic [31:0]       width_q, width_d;
  logic [31:0]       gap_q, gap_d;
  logic [31:0]       steps_q, steps_d;
  logic [31:0]       deadline_q, deadline_d;
  logic              dir_q, dir_d;

  logic              accept;
  logic              commit;
  logic              ram_we;
  logic [QIDX_W-1:0] tail;
  logic [CNT_W:0]    tail_sum;
  seg_t              seg_wr;
  seg_t              seg_rd;
  logic [SEG_W-1:0]  seg_rd_raw;
  logic [31:0]       diff;
  logic              seg_ok;
  logic              do_load;
  logic              force_dir;
  out_res_t          res;

  assign accept = in_valid_i && in_ready_o;
  assign commit = (ctl_q == CTL_EXEC) && res_ready_i;

  assign seg_wr = '{
    count:  req_q.seg_step_count,
    start:  req_q.seg_start_time,
    period: req_q.seg_period,
    width:  req_q.seg_pulse_width,
    dir:    req_q.seg_direction
  };

  assign tail_sum = {{(CNT_W + 1 - QIDX_W){1'b0}}, head_q} + {1'b0, fill_q};
  assign tail = (tail_sum >= (CNT_W + 1)'(QUEUE_DEPTH))
              ? QIDX_W'(tail_sum - (CNT_W + 1)'(QUEUE_DEPTH))
              : QIDX_W'(tail_sum);

  ssq_seg_ram #(
    .DataWidth(SEG_W),
    .Depth    (QUEUE_DEPTH)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we && commit),
    .waddr_i(tail),
    .wdata_i(seg_wr),
    .re_i   (accept),
    .raddr_i(head_q),
    .rdata_o(seg_rd_raw)
  );

  assign seg_rd = seg_t'(seg_rd_raw);

  assign seg_ok = (req_q.seg_step_count != '0) && (req_q.seg_period != '0)
               && (req_q.seg_pulse_width != '0)
               && (req_q.seg_pulse_width < req_q.seg_period);

  assign diff = req_q.now - ((req_e'(req_q.req_type) == REQ_START) ? seg_rd.start : deadline_q);

  always_comb begin
    ctl_d = ctl_q;
    case (ctl_q)
      CTL_IDLE: begin
        if (accept) begin
          ctl_d = CTL_EXEC;
        end
      end
      CTL_EXEC: begin
        if (res_ready_i) begin
          ctl_d = CTL_IDLE;
        end
      end
      default: ctl_d = CTL_IDLE;
    endcase
  end

  always_comb begin
    res        = '0;
    ram_we     = 1'b0;
    do_load    = 1'b0;
    force_dir  = 1'b0;
    head_d     = head_q;
    fill_d     = fill_q;
    phase_d    = phase_q;
    width_d    = width_q;
    gap_d      = gap_q;
    steps_d    = steps_q;
    deadline_d = deadline_q;
    dir_d      = dir_q;

    case (req_e'(req_q.req_type))
      REQ_ENQUEUE: begin
        if ((fill_q < CNT_W'(QUEUE_DEPTH)) && seg_ok) begin
          ram_we       = 1'b1;
          fill_d       = fill_q + CNT_W'(1);
          res.accepted = 1'b1;
        end
      end
      REQ_START: begin
        if (phase_q == PH_IDLE) begin
          do_load   = 1'b1;
          force_dir = 1'b1;
          if ((fill_q != '0) && !diff[31]) begin
            res.accepted   = 1'b1;
            res.late_ticks = diff;
          end else if (fill_q != '0) begin
            res.accepted = 1'b1;
          end
        end
      end
      REQ_DEADLINE: begin
        if (phase_q != PH_IDLE) begin
          if (diff[31]) begin
            res.due_at    = deadline_q;
            res.due_valid = 1'b1;
          end else begin
            res.accepted   = 1'b1;
            res.late_ticks = diff;
            if (phase_q == PH_RISE) begin
              res.raise_step = 1'b1;
              deadline_d     = deadline_q + width_q;
              phase_d        = PH_FALL;
              res.due_at     = deadline_d;
              res.due_valid  = 1'b1;
            end else begin
              res.lower_step = 1'b1;
              steps_d        = steps_q - 32'd1;
              if (steps_q == 32'd1) begin
                res.segment_done = 1'b1;
                do_load          = 1'b1;
              end else begin
                deadline_d    = deadline_q + gap_q;
                phase_d       = PH_RISE;
                res.due_at    = deadline_d;
                res.due_valid = 1'b1;
              end
            end
          end
        end
      end
      default: ;
    endcase

    if (do_load) begin
      if (fill_q == '0) begin
        phase_d         = PH_IDLE;
        res.queue_empty = 1'b1;
        res.due_valid   = 1'b0;
        res.due_at      = '0;
      end else begin
        head_d     = (head_q == QIDX_W'(QUEUE_DEPTH - 1)) ? '0 : head_q + QIDX_W'(1);
        fill_d     = fill_q - CNT_W'(1);
        steps_d    = seg_rd.count;
        deadline_d = seg_rd.start;
        width_d    = seg_rd.width;
        gap_d      = seg_rd.period - seg_rd.width;
        phase_d    = PH_RISE;
        if (force_dir || (dir_q != seg_rd.dir)) begin
          dir_d             = seg_rd.dir;
          res.set_direction = 1'b1;
          res.direction_out = seg_rd.dir;
        end
        res.due_at    = seg_rd.start;
        res.due_valid = 1'b1;
      end
    end

    res.queued_count = QCNT_W'(fill_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q      <= CTL_IDLE;
      head_q     <= '0;
      fill_q     <= '0;
      phase_q    <= PH_IDLE;
      width_q    <= '0;
      gap_q      <= '0;
      steps_q    <= '0;
      deadline_q <= '0;
      dir_q      <= 1'b0;
    end else begin
      ctl_q <= ctl_d;
      if (commit) begin
        head_q     <= head_d;
        fill_q     <= fill_d;
        phase_q    <= phase_d;
        width_q    <= width_d;
        gap_q      <= gap_d;
        steps_q    <= steps_d;
        deadline_q <= deadline_d;
        dir_q      <= dir_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q <= in_req_i;
    end
  end

  assign in_ready_o  = (ctl_q == CTL_IDLE);
  assign res_valid_o = (ctl_q == CTL_EXEC);
  assign res_o       = res;

endmodule

// ===== hdl/step_pulse_segment_sequencer.sv =====
// Step/direction pulse sequencer with a ring queue of motion segments.
// Input channel (in_valid_i/in_ready_o, in_req_i): one request each, to
// enqueue a segment, start motion, or check the step deadline against now.
// Output channel (out_valid_o/out_ready_i, out_res_o): exactly one result
// per request, in request order.
// Order of events: an accepted request reads the head segment from the
// segment memory at its accept edge, is evaluated in the next cycle, and
// its result is written into the output register when that register is
// free; the receiver takes it from the output register.
// The engine takes no new request until its current result is registered:
// each request is a registered read of the segment memory followed by the read-modify-write cycle of the engine.
// The output register holds a result while the receiver stalls; the next
// request is still accepted and waits in its evaluate cycle until the
// output register drains.
// Reset clears the queue pointers, fill count and engine phase (idle);
// segment memory contents are not cleared and need no clearing pass.
module step_pulse_segment_sequencer (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  ssq_pkg::in_req_t  in_req_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output ssq_pkg::out_res_t out_res_o
);
  import ssq_pkg::*;

  logic     res_valid;
  logic     res_ready;
  out_res_t res;
  logic     out_valid_q, out_valid_d;
  out_res_t out_res_q;

  ssq_engine u_engine (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_req_i   (in_req_i),
    .res_valid_o(res_valid),
    .res_ready_i(res_ready),
    .res_o      (res)
  );

  assign res_ready = !out_valid_q || out_ready_i;

  always_comb begin
    out_valid_d = out_valid_q;
    if (res_valid && res_ready) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      out_res_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_res_o   = out_res_q;

endmodule

// ===== tb/sv/step_pulse_segment_sequencer_checker.sv =====
`timescale 1ns / 1ps

module step_pulse_segment_sequencer_checker (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_ready_i,
  input  ssq_pkg::in_req_t  in_req_i,
  input  logic              out_valid_i,
  input  logic              out_ready_i,
  input  ssq_pkg::out_res_t out_res_i,
  output int                fail_cnt_o,
  output int                pending_o,
  output int                checked_o,
  output int                pulses_o,
  output int                segs_done_o,
  output int                refused_o
);
  import ssq_pkg::*;

  localparam int PRINT_CAP = 40;

  logic [31:0] ring_cnt   [QUEUE_DEPTH];
  logic [31:0] ring_start [QUEUE_DEPTH];
  logic [31:0] ring_per   [QUEUE_DEPTH];
  logic [31:0] ring_wid   [QUEUE_DEPTH];
  logic        ring_dir   [QUEUE_DEPTH];
  int          ring_head;
  int          ring_fill;
  phase_e      eng_phase;
  logic [31:0] run_period;
  logic [31:0] run_width;
  logic [31:0] steps_rem;
  logic [31:0] due_time;
  logic        cur_dir;

  out_res_t    step_results_q[$];
  out_res_t    next_want;
  int          fails;
  int          checked;
  int          pulses;
  int          segs_done;
  int          refused;

  function automatic bit load_next(inout out_res_t o, input bit force_dir);
    int slot;
    if (ring_fill == 0) begin
      eng_phase     = PH_IDLE;
      o.queue_empty = 1'b1;
      o.due_valid   = 1'b0;
      o.due_at      = '0;
      return 1'b0;
    end
    slot       = ring_head;
    ring_head  = (ring_head + 1) % QUEUE_DEPTH;
    ring_fill  = ring_fill - 1;
    steps_rem  = ring_cnt[slot];
    due_time   = ring_start[slot];
    run_period = ring_per[slot];
    run_width  = ring_wid[slot];
    eng_phase  = PH_RISE;
    if (force_dir || cur_dir != ring_dir[slot]) begin
      cur_dir         = ring_dir[slot];
      o.set_direction = 1'b1;
      o.direction_out = cur_dir;
    end
    o.due_at    = due_time;
    o.due_valid = 1'b1;
    return 1'b1;
  endfunction

  function automatic out_res_t predict_step(in_req_t r);
    out_res_t    o;
    logic [31:0] lag;
    bit          seg_ok;
    int          tail;
    o   = '0;
    lag = r.now - due_time;
    case (r.req_type)
      REQ_ENQUEUE: begin
        seg_ok = r.seg_step_count != 0 && r.seg_period != 0 && r.seg_pulse_width != 0 &&
                 r.seg_pulse_width < r.seg_period;
        if (ring_fill < QUEUE_DEPTH && seg_ok) begin
          tail             = (ring_head + ring_fill) % QUEUE_DEPTH;
          ring_cnt[tail]   = r.seg_step_count;
          ring_start[tail] = r.seg_start_time;
          ring_per[tail]   = r.seg_period;
          ring_wid[tail]   = r.seg_pulse_width;
          ring_dir[tail]   = r.seg_direction;
          ring_fill        = ring_fill + 1;
          o.accepted       = 1'b1;
        end
      end
      REQ_START: begin
        if (eng_phase == PH_IDLE && load_next(o, 1'b1)) begin
          o.accepted = 1'b1;
          lag        = r.now - due_time;
          if (!lag[31]) o.late_ticks = lag;
        end
      end
      REQ_DEADLINE: begin
        if (eng_phase != PH_IDLE) begin
          if (lag[31]) begin
            o.due_at    = due_time;
            o.due_valid = 1'b1;
          end else begin
            o.accepted   = 1'b1;
            o.late_ticks = lag;
            if (eng_phase == PH_RISE) begin
              o.raise_step = 1'b1;
              due_time     = due_time + run_width;
              eng_phase    = PH_FALL;
              o.due_at     = due_time;
              o.due_valid  = 1'b1;
            end else begin
              o.lower_step = 1'b1;
              steps_rem    = steps_rem - 1;
              if (steps_rem == 0) begin
                o.segment_done = 1'b1;
                void'(load_next(o, 1'b0));
              end else begin
                due_time    = due_time + run_period - run_width;
                eng_phase   = PH_RISE;
                o.due_at    = due_time;
                o.due_valid = 1'b1;
              end
            end
          end
        end
      end
      default: ;
    endcase
    o.queued_count = QCNT_W'(ring_fill);
    return o;
  endfunction

  task automatic report_mismatch(string msg);
    fails++;
    if (fails <= PRINT_CAP) $display("[%0t] mismatch: %s", $realtime, msg);
  endtask

  task automatic cmp_field(string fname, logic [31:0] got, logic [31:0] want);
    if (got !== want)
      report_mismatch($sformatf("result %0d %s: got %0h, expected %0h",
                                checked, fname, got, want));
  endtask

  task automatic check_result(out_res_t got);
    out_res_t want;
    if (step_results_q.size() == 0) begin
      report_mismatch("result with no request outstanding");
      return;
    end
    want = step_results_q.pop_front();
    cmp_field("accepted",      32'(got.accepted),      32'(want.accepted));
    cmp_field("set_direction", 32'(got.set_direction), 32'(want.set_direction));
    cmp_field("direction_out", 32'(got.direction_out), 32'(want.direction_out));
    cmp_field("raise_step",    32'(got.raise_step),    32'(want.raise_step));
    cmp_field("lower_step",    32'(got.lower_step),    32'(want.lower_step));
    cmp_field("segment_done",  32'(got.segment_done),  32'(want.segment_done));
    cmp_field("queue_empty",   32'(got.queue_empty),   32'(want.queue_empty));
    cmp_field("due_valid",     32'(got.due_valid),     32'(want.due_valid));
    cmp_field("due_at",        got.due_at,             want.due_at);
    cmp_field("late_ticks",    got.late_ticks,         want.late_ticks);
    cmp_field("queued_count",  32'(got.queued_count),  32'(want.queued_count));
    checked++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ring_head  = 0;
      ring_fill  = 0;
      eng_phase  = PH_IDLE;
      run_period = '0;
      run_width  = '0;
      steps_rem  = '0;
      due_time   = '0;
      cur_dir    = 1'b0;
      step_results_q.delete();
    end else begin
      if (out_valid_i && out_ready_i) check_result(out_res_i);
      if (in_valid_i && in_ready_i) begin
        next_want = predict_step(in_req_i);
        if (next_want.lower_step) pulses++;
        if (next_want.segment_done) segs_done++;
        if (!next_want.accepted) refused++;
        step_results_q.push_back(next_want);
      end
    end
    fail_cnt_o  <= fails;
    pending_o   <= step_results_q.size();
    checked_o   <= checked;
    pulses_o    <= pulses;
    segs_done_o <= segs_done;
    refused_o   <= refused;
  end

endmodule

// ===== tb/sv/step_pulse_segment_sequencer_tb.sv =====
`timescale 1ns / 1ps

module step_pulse_segment_sequencer_tb;
  import ssq_pkg::*;

  localparam logic [1:0] REQ_UNUSED   = 2'd3;
  localparam int         RANDOM_ITEMS = 800;
  localparam int         CYCLE_LIMIT  = 200000;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  in_req_t     in_req;
  logic        out_valid;
  logic        out_ready;
  out_res_t    out_res;

  int          fail_cnt;
  int          pending;
  int          checked;
  int          pulses;
  int          segs_done;
  int          refused;

  int          cycle_cnt = 0;
  int          sent_cnt  = 0;
  int          rx_wait   = 0;
  bit          tx_fast   = 1'b0;
  bit          rx_fast   = 1'b0;
  logic [31:0] mclk      = '0;
  logic [31:0] seen_dl   = '0;

  step_pulse_segment_sequencer DUT (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_req_i    (in_req),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_res_o   (out_res)
  );

  step_pulse_segment_sequencer_checker u_checker (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_i  (in_ready),
    .in_req_i    (in_req),
    .out_valid_i (out_valid),
    .out_ready_i (out_ready),
    .out_res_i   (out_res),
    .fail_cnt_o  (fail_cnt),
    .pending_o   (pending),
    .checked_o   (checked),
    .pulses_o    (pulses),
    .segs_done_o (segs_done),
    .refused_o   (refused)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_cnt, pending);
      $display("== FAIL ==");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if ($urandom_range(0, 39) == 0) rx_fast = !rx_fast;
        rx_wait = rx_fast ? 0 : $urandom_range(0, 6);
      end
      if (rx_wait > 0) begin
        rx_wait--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // track the engine's pending edge so ticks can catch up with it
  always @(posedge clk) begin
    if (out_valid && out_ready && out_res.due_valid) seen_dl <= out_res.due_at;
  end

  task automatic send(logic [1:0] kind, logic [31:0] now, logic [31:0] cnt,
                      logic [31:0] first, logic [31:0] per, logic [31:0] wid, logic dir);
    int gap;
    gap = tx_fast ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_req   <= '{req_type: kind, now: now, seg_step_count: cnt, seg_start_time: first,
                  seg_period: per, seg_pulse_width: wid, seg_direction: dir};
    do @(posedge clk); while (!in_ready);
    if (kind != REQ_UNUSED) sent_cnt++;
  endtask

  task automatic send_bare(logic [1:0] kind, logic [31:0] now);
    send(kind, now, $urandom, $urandom, $urandom, $urandom, 1'($urandom));
  endtask

  task automatic enq_good(input int max_cnt, output int cnt_o);
    logic [31:0] per;
    logic [31:0] wid;
    if ($urandom_range(0, 15) == 0) begin
      per = $urandom | 32'h8000_0000;
      wid = $urandom % per;
      if (wid == 0) wid = 1;
    end else begin
      per = $urandom_range(2, 24);
      wid = $urandom_range(1, per - 1);
    end
    cnt_o = $urandom_range(1, max_cnt);
    send(REQ_ENQUEUE, mclk, cnt_o, mclk + $urandom_range(0, 30), per, wid, 1'($urandom));
  endtask

  task automatic enq_noise();
    logic [31:0] cnt;
    logic [31:0] per;
    logic [31:0] wid;
    cnt = $urandom;
    per = $urandom;
    wid = $urandom;
    if ($urandom_range(0, 1)) cnt = cnt & 32'hF;
    // refuse long segments so the engine can drain
    if (cnt > 16 && wid != 0 && wid < per) wid = '0;
    send(REQ_ENQUEUE, $urandom, cnt, $urandom, per, wid, 1'($urandom));
  endtask

  task automatic enq_broken();
    case ($urandom_range(0, 3))
      0:       send(REQ_ENQUEUE, mclk, '0, mclk, 10, 3, 1'($urandom));
      1:       send(REQ_ENQUEUE, mclk, $urandom_range(1, 4), mclk, '0, 3, 1'($urandom));
      2:       send(REQ_ENQUEUE, mclk, $urandom_range(1, 4), mclk, 10, '0, 1'($urandom));
      default: send(REQ_ENQUEUE, mclk, $urandom_range(1, 4), mclk, 8, $urandom_range(8, 40),
                    1'($urandom));
    endcase
  endtask

  task automatic deadline_tick();
    logic [31:0] now;
    int          pick;
    pick = $urandom_range(0, 19);
    if (pick == 0) begin
      now = $urandom;
    end else begin
      if (pick < 5) mclk = seen_dl + $urandom_range(0, 2);
      else mclk = mclk + $urandom_range(0, 6);
      now = mclk;
    end
    send_bare(REQ_DEADLINE, now);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  initial begin
    int pick;
    int n;
    int steps;
    int c;
    int rand_base;
    bit first_seq;

    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_req    = '0;
    out_ready = 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_bare(REQ_DEADLINE, '0);
    send_bare(REQ_START, '0);
    send_bare(REQ_UNUSED, $urandom);
    send(REQ_ENQUEUE, '0, '0, 32'h10, 10, 5, 1'b1);
    send(REQ_ENQUEUE, '0, 5, 32'h10, '0, 3, 1'b0);
    send(REQ_ENQUEUE, '0, 5, 32'h10, 10, '0, 1'b1);
    send(REQ_ENQUEUE, '0, 5, 32'h10, 10, 10, 1'b0);
    send(REQ_ENQUEUE, '1, '1, '1, 7, '1, 1'b1);
    send(REQ_ENQUEUE, '0, 1, 32'hFFFF_FFF0, 32'hFFFF_FFFF, 32'hFFFF_FFFE, 1'b1);
    send(REQ_ENQUEUE, '0, 2, 32'h0000_0010, 6, 1, 1'b1);
    send(REQ_ENQUEUE, '0, 1, 32'h7FFF_FFF0, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0);
    send_bare(REQ_START, 32'hFFFF_FFEF);
    send_bare(REQ_START, 32'hFFFF_FFF0);
    send_bare(REQ_DEADLINE, 32'hFFFF_FFEF);
    send_bare(REQ_DEADLINE, 32'h7FFF_FFEF);
    send_bare(REQ_DEADLINE, 32'h7FFF_FFEE);
    send_bare(REQ_DEADLINE, 32'hFFFF_FFEE);
    send_bare(REQ_DEADLINE, 32'h0000_0020);
    send_bare(REQ_DEADLINE, 32'h0000_0011);
    send_bare(REQ_DEADLINE, 32'h0000_0016);
    send_bare(REQ_DEADLINE, 32'h0000_0017);
    send_bare(REQ_DEADLINE, 32'hFFFF_FFFF);
    send_bare(REQ_DEADLINE, 32'h7FFF_FFF0);
    send_bare(REQ_DEADLINE, 32'hFFFF_FFEF);
    send(REQ_ENQUEUE, 32'h10, 1, 32'h0000_0005, 4, 2, 1'b0);
    send_bare(REQ_START, 32'h0000_0010);

    // start near the wrap point of the motion clock
    mclk      = 32'hFFFF_FF00;
    rand_base = sent_cnt;
    first_seq = 1'b1;
    while (sent_cnt - rand_base < RANDOM_ITEMS) begin
      tx_fast = ($urandom_range(0, 3) == 0);
      pick    = first_seq ? 6 : $urandom_range(0, 11);
      steps   = 0;
      case (pick)
        6: begin
          n = $urandom_range(15, 18);
          repeat (n) begin
            enq_good(2, c);
            steps += c;
          end
          send_bare(REQ_START, mclk);
          repeat (2 * steps + 4) deadline_tick();
        end
        7: begin
          repeat ($urandom_range(1, 6)) begin
            if ($urandom_range(0, 3) == 0) enq_noise();
            else send_bare(2'($urandom_range(1, 3)), $urandom);
          end
        end
        8: begin
          send_bare(REQ_START, $urandom);
          repeat ($urandom_range(1, 3)) enq_broken();
          send_bare(REQ_DEADLINE, $urandom);
        end
        9: wait_drained();
        default: begin
          n = $urandom_range(1, 4);
          repeat (n) begin
            enq_good(3, c);
            steps += c;
          end
          send_bare(REQ_START, mclk + $urandom_range(0, 40));
          repeat (2 * steps + $urandom_range(0, 4)) begin
            if ($urandom_range(0, 9) == 0) enq_good(3, c);
            deadline_tick();
          end
        end
      endcase
      if (first_seq) wait_drained();
      first_seq = 1'b0;
    end

    wait_drained();
    repeat (8) @(posedge clk);
    $display("%0d requests sent (%0d directed), %0d results checked",
             sent_cnt, rand_base, checked);
    $display("%0d step pulses, %0d segments completed, %0d requests refused",
             pulses, segs_done, refused);
    if (fail_cnt == 0 && pending == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d mismatches, %0d results outstanding", fail_cnt, pending);
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
